/* rtl/ptts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; used by every module of the block.
package ptts_pkg;

   localparam int TICK_W     = 24;
   localparam int DATA_W     = 32;
   localparam int CNT_W      = $clog2(TICK_W);
   localparam int SLOTS_DEF  = 16;
   localparam int TIMERS_DEF = 2;

   localparam logic [TICK_W-1:0] TICK_WRAP_RESET = TICK_W'(1000 * 10 * 1000);

   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_REG     = 3'd1,
      MODE_COLLECT = 3'd2,
      MODE_START   = 3'd3,
      MODE_STOP    = 3'd4,
      MODE_CLEAR   = 3'd5,
      MODE_READ    = 3'd6,
      MODE_DELAY   = 3'd7
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [TICK_W-1:0] interval;
      logic [1:0]        timer_index;
      logic [DATA_W-1:0] delay_ms;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [3:0]        slot;
      logic [15:0]       pending;
      logic [DATA_W-1:0] timer_value;
      logic [DATA_W-1:0] delay_left;
      logic [TICK_W-1:0] tick_now;
   } rsp_type;

   // command to the shared remainder unit
   typedef struct packed {
      logic              start;
      logic [TICK_W-1:0] dividend;
      logic [TICK_W-1:0] divisor;
   } mod_cmd_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } mod_sts_type;

endpackage

/* rtl/ptts_mod_unit.sv */
`timescale 1ns / 1ps
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on ptts_pkg.
module ptts_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  ptts_pkg::mod_cmd_type cmd,
   output ptts_pkg::mod_sts_type sts
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ptts_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ptts_pkg::TICK_W-1:0]   rem_ff, rem_in;
   logic [ptts_pkg::TICK_W-1:0]   dvd_ff, dvd_in;
   logic [ptts_pkg::TICK_W-1:0]   div_ff, div_in;
   logic [ptts_pkg::TICK_W:0]     trial;
   logic [ptts_pkg::TICK_W:0]     diff;
   logic                          fits;

   assign trial = {rem_ff, dvd_ff[ptts_pkg::TICK_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = cmd.dividend;
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[ptts_pkg::TICK_W-1:0] : trial[ptts_pkg::TICK_W-1:0];
         dvd_in = {dvd_ff[ptts_pkg::TICK_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ptts_pkg::CNT_W'(ptts_pkg::TICK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign sts.done     = done_ff;
   assign sts.rem_zero = (rem_ff == '0);

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("remainder unit restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("remainder done held for more than one cycle");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff))
      else $error("remainder done without a running division");
`endif

endmodule

/* rtl/ptts_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer and state of the scheduler: slot table, period memory, timers,
// delay countdown. Drives the shared remainder unit. Depends on ptts_pkg.
module ptts_ctrl #(
   parameter int SLOTS  = ptts_pkg::SLOTS_DEF,
   parameter int TIMERS = ptts_pkg::TIMERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_take,
   input  ptts_pkg::req_type           req_data,
   output logic                        idle,
   input  logic [ptts_pkg::TICK_W-1:0] wrap_limit,
   output logic                        res_valid,
   input  logic                        res_take,
   output ptts_pkg::rsp_type           res,
   output ptts_pkg::mod_cmd_type       mod_cmd,
   input  ptts_pkg::mod_sts_type       mod_sts
);

   localparam int SLOT_IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TIMER_IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SCAN,
      ST_LOAD,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [SLOT_IW-1:0]             idx_ff, idx_in;
   logic [ptts_pkg::TICK_W-1:0]    tick_ff, tick_in;
   logic [ptts_pkg::DATA_W-1:0]    delay_ff, delay_in;
   logic [SLOTS-1:0]               used_ff, used_in;
   logic [SLOTS-1:0]               pend_ff, pend_in;
   logic [TIMERS-1:0]              run_ff, run_in;
   logic [ptts_pkg::DATA_W-1:0]    tcount_ff [TIMERS];
   logic [ptts_pkg::DATA_W-1:0]    tcount_in [TIMERS];
   logic [ptts_pkg::TICK_W-1:0]    interval_ff, interval_in;
   ptts_pkg::rsp_type              res_ff, res_in;

   logic [ptts_pkg::TICK_W-1:0]    period_mem [SLOTS];
   logic [ptts_pkg::TICK_W-1:0]    period_rd_ff;
   logic                           mem_we;

   logic                           tidx_ok;
   logic [TIMER_IW-1:0]            tsel;

   assign tidx_ok = 32'(req_data.timer_index) < TIMERS;
   assign tsel    = req_data.timer_index[TIMER_IW-1:0];

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      tick_in     = tick_ff;
      delay_in    = delay_ff;
      used_in     = used_ff;
      pend_in     = pend_ff;
      run_in      = run_ff;
      tcount_in   = tcount_ff;
      interval_in = interval_ff;
      res_in      = res_ff;
      mem_we      = 1'b0;
      mod_cmd.start    = 1'b0;
      mod_cmd.dividend = tick_ff;
      mod_cmd.divisor  = period_rd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               interval_in = req_data.interval;
               res_in      = '0;
               state_in    = ST_DONE;
               unique case (req_data.mode)
                  ptts_pkg::MODE_TICK: begin
                     if (tick_ff < wrap_limit) begin
                        tick_in = tick_ff + 1'b1;
                     end else begin
                        tick_in = '0;
                     end
                     if (delay_ff != '0) begin
                        delay_in = delay_ff - 1'b1;
                     end
                     for (int t = 0; t < TIMERS; t++) begin
                        if (run_ff[t]) begin
                           tcount_in[t] = tcount_ff[t] + 1'b1;
                        end
                     end
                     res_in.ok = 1'b1;
                     idx_in    = '0;
                     state_in  = ST_SCAN;
                  end
                  ptts_pkg::MODE_REG: begin
                     if (req_data.interval != '0) begin
                        idx_in   = '0;
                        state_in = ST_FIND;
                     end
                  end
                  ptts_pkg::MODE_COLLECT: begin
                     res_in.pending = 16'(used_ff & pend_ff);
                     pend_in        = pend_ff & ~used_ff;
                     res_in.ok      = 1'b1;
                  end
                  ptts_pkg::MODE_START: begin
                     if (tidx_ok) begin
                        run_in[tsel] = 1'b1;
                        res_in.ok    = 1'b1;
                     end
                  end
                  ptts_pkg::MODE_STOP: begin
                     if (tidx_ok) begin
                        run_in[tsel] = 1'b0;
                        res_in.ok    = 1'b1;
                     end
                  end
                  ptts_pkg::MODE_CLEAR: begin
                     if (tidx_ok) begin
                        tcount_in[tsel] = '0;
                        res_in.ok       = 1'b1;
                     end
                  end
                  ptts_pkg::MODE_READ: begin
                     if (tidx_ok) begin
                        res_in.timer_value = tcount_ff[tsel];
                        res_in.ok          = 1'b1;
                     end
                  end
                  ptts_pkg::MODE_DELAY: begin
                     delay_in  = req_data.delay_ms;
                     res_in.ok = 1'b1;
                  end
               endcase
            end
         end
         ST_FIND: begin
            // first free slot, one slot a cycle
            if (!used_ff[idx_ff]) begin
               mem_we          = 1'b1;
               used_in[idx_ff] = 1'b1;
               pend_in[idx_ff] = 1'b0;
               res_in.ok       = 1'b1;
               res_in.slot     = 4'(idx_ff);
               state_in        = ST_DONE;
            end else if (idx_ff == LAST_SLOT) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (used_ff[idx_ff]) begin
               state_in = ST_LOAD;
            end else if (idx_ff == LAST_SLOT) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            // period read issued in scan is now in period_rd_ff
            mod_cmd.start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (mod_sts.done) begin
               if (mod_sts.rem_zero && period_rd_ff != '0) begin
                  pend_in[idx_ff] = 1'b1;
               end
               if (idx_ff == LAST_SLOT) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         tick_ff  <= '0;
         delay_ff <= '0;
         used_ff  <= '0;
         pend_ff  <= '0;
         run_ff   <= '0;
         for (int t = 0; t < TIMERS; t++) begin
            tcount_ff[t] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         tick_ff   <= tick_in;
         delay_ff  <= delay_in;
         used_ff   <= used_in;
         pend_ff   <= pend_in;
         run_ff    <= run_in;
         tcount_ff <= tcount_in;
      end
      interval_ff <= interval_in;
      res_ff      <= res_in;
   end

   // period store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         period_mem[idx_ff] <= interval_ff;
      end
      period_rd_ff <= period_mem[idx_ff];
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res            = res_ff;
      res.delay_left = delay_ff;
      res.tick_now   = tick_ff;
   end

`ifndef SYNTHESIS
   a_pend_used: assert property (@(posedge clock) disable iff (reset)
      (pend_ff & ~used_ff) == '0)
      else $error("pending flag on a free slot");
   a_used_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (($past(used_ff) & ~used_ff) == '0))
      else $error("slot released");
   a_delay_load: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && delay_ff > $past(delay_ff)) |->
         ($past(req_take) && $past(req_data.mode) == ptts_pkg::MODE_DELAY))
      else $error("delay countdown grew without a delay request");
`endif

endmodule

/* rtl/periodic_task_tick_scheduler_core.sv */
`timescale 1ns / 1ps
// Tick scheduler top: wrap-limit register, result register, handshakes.
// Tick: scans every slot and runs the shared 24-step remainder unit once for
// each used slot. Register: searches the slot table for the first free slot.
// All other requests go straight from idle to the result state. One request at a time; a result may wait in
// the output register while the next request is taken.
// Synchronous reset clears control state and loads the wrap limit 10000000.
module periodic_task_tick_scheduler_core #(
   parameter int SLOTS  = ptts_pkg::SLOTS_DEF,
   parameter int TIMERS = ptts_pkg::TIMERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ptts_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ptts_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ptts_pkg::TICK_W-1:0] csr_data
);

   logic [ptts_pkg::TICK_W-1:0] wrap_ff, wrap_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ptts_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic                        idle;
   logic                        res_valid;
   logic                        res_take;
   ptts_pkg::rsp_type           res;
   ptts_pkg::mod_cmd_type       mod_cmd;
   ptts_pkg::mod_sts_type       mod_sts;
   logic                        req_take;

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign req_take  = req_valid && idle;
   assign res_take  = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      wrap_in      = (csr_valid && csr_ready) ? csr_data : wrap_ff;
      rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = res_take ? res : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff      <= ptts_pkg::TICK_WRAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ptts_ctrl #(
      .SLOTS  (SLOTS),
      .TIMERS (TIMERS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_take   (req_take),
      .req_data   (req_data),
      .idle       (idle),
      .wrap_limit (wrap_ff),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res),
      .mod_cmd    (mod_cmd),
      .mod_sts    (mod_sts)
   );

   ptts_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (mod_cmd),
      .sts   (mod_sts)
   );

endmodule

/* tb/sv/periodic_task_tick_scheduler_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for periodic_task_tick_scheduler_core: a queue-fed request
// driver that runs the scheduler predictor, a result monitor, phased wrap settings.
// Depends on ptts_pkg and the core RTL only.
module periodic_task_tick_scheduler_core_tb;

   localparam int  TICK_W      = ptts_pkg::TICK_W;
   localparam int  DATA_W      = ptts_pkg::DATA_W;
   localparam int  NSLOT       = ptts_pkg::SLOTS_DEF;
   localparam int  NTIMER      = ptts_pkg::TIMERS_DEF;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  TAIL_CYCLES = 600;
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   ptts_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   ptts_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [TICK_W-1:0] csr_data;

   periodic_task_tick_scheduler_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // predictor state
   logic [TICK_W-1:0] wrap_limit_mdl;
   logic [TICK_W-1:0] tick_mdl;
   logic              used_mdl    [NSLOT];
   logic [TICK_W-1:0] period_mdl  [NSLOT];
   logic              pending_mdl [NSLOT];
   logic              running_mdl [4];
   logic [DATA_W-1:0] timer_mdl   [4];
   logic [DATA_W-1:0] delay_mdl;

   ptts_pkg::req_type req_backlog[$];
   ptts_pkg::rsp_type due_results[$];
   int      send_idle_pct;
   int      recv_stall_pct;
   int      error_total = 0;
   int      cycle_count = 0;

   function automatic ptts_pkg::rsp_type sched_step(ptts_pkg::req_type rq);
      ptts_pkg::rsp_type r;
      logic    idx_ok;
      logic    claimed;
      r       = '0;
      idx_ok  = rq.timer_index < NTIMER;
      claimed = 1'b0;
      case (rq.mode)
         ptts_pkg::MODE_TICK: begin
            if (tick_mdl < wrap_limit_mdl) tick_mdl = tick_mdl + 1'b1;
            else tick_mdl = '0;
            if (delay_mdl != 0) delay_mdl = delay_mdl - 1;
            for (int n = 0; n < NSLOT; n++)
               if (used_mdl[n] && period_mdl[n] != 0 && (tick_mdl % period_mdl[n]) == 0)
                  pending_mdl[n] = 1'b1;
            for (int n = 0; n < NTIMER; n++)
               if (running_mdl[n]) timer_mdl[n] = timer_mdl[n] + 1;
            r.ok = 1'b1;
         end
         ptts_pkg::MODE_REG: begin
            if (rq.interval != 0) begin
               for (int n = 0; n < NSLOT; n++) begin
                  if (!claimed && !used_mdl[n]) begin
                     claimed        = 1'b1;
                     used_mdl[n]    = 1'b1;
                     period_mdl[n]  = rq.interval;
                     pending_mdl[n] = 1'b0;
                     r.ok           = 1'b1;
                     r.slot         = 4'(n);
                  end
               end
            end
         end
         ptts_pkg::MODE_COLLECT: begin
            for (int n = 0; n < NSLOT; n++) begin
               if (used_mdl[n] && pending_mdl[n] && n < 16) r.pending[n] = 1'b1;
               if (used_mdl[n]) pending_mdl[n] = 1'b0;
            end
            r.ok = 1'b1;
         end
         ptts_pkg::MODE_START: if (idx_ok) begin
            running_mdl[rq.timer_index] = 1'b1;
            r.ok = 1'b1;
         end
         ptts_pkg::MODE_STOP: if (idx_ok) begin
            running_mdl[rq.timer_index] = 1'b0;
            r.ok = 1'b1;
         end
         ptts_pkg::MODE_CLEAR: if (idx_ok) begin
            timer_mdl[rq.timer_index] = '0;
            r.ok = 1'b1;
         end
         ptts_pkg::MODE_READ: if (idx_ok) begin
            r.timer_value = timer_mdl[rq.timer_index];
            r.ok = 1'b1;
         end
         default: begin
            delay_mdl = rq.delay_ms;
            r.ok = 1'b1;
         end
      endcase
      r.delay_left = delay_mdl;
      r.tick_now   = tick_mdl;
      return r;
   endfunction

   // request driver: next request offered only once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         tick_mdl  = '0;
         delay_mdl = '0;
         for (int n = 0; n < NSLOT; n++) begin
            used_mdl[n]    = 1'b0;
            period_mdl[n]  = '0;
            pending_mdl[n] = 1'b0;
         end
         for (int n = 0; n < 4; n++) begin
            running_mdl[n] = 1'b0;
            timer_mdl[n]   = '0;
         end
      end else begin
         if (req_valid && !req_stall) due_results.push_back(sched_step(req_data));
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_total++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      ptts_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("result with no request outstanding");
               error_total++;
            end else begin
               want = due_results.pop_front();
               check_field("ok", want.ok, rsp_data.ok);
               check_field("slot", want.slot, rsp_data.slot);
               check_field("pending", want.pending, rsp_data.pending);
               check_field("timer_value", want.timer_value, rsp_data.timer_value);
               check_field("delay_left", want.delay_left, rsp_data.delay_left);
               check_field("tick_now", want.tick_now, rsp_data.tick_now);
            end
         end
         rsp_stall <= $urandom_range(0, 99) < recv_stall_pct;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic ptts_pkg::req_type make_req(ptts_pkg::mode_type m,
                                                  logic [TICK_W-1:0] ival,
                                                  logic [1:0] idx,
                                                  logic [DATA_W-1:0] dly);
      ptts_pkg::req_type rq;
      rq.mode        = m;
      rq.interval    = ival;
      rq.timer_index = idx;
      rq.delay_ms    = dly;
      return rq;
   endfunction

   // all fields random, then the field the mode uses is shaped
   function automatic ptts_pkg::req_type random_req();
      ptts_pkg::req_type rq;
      int      r;
      rq = make_req(ptts_pkg::MODE_TICK, TICK_W'($urandom), 2'($urandom), $urandom);
      r  = $urandom_range(0, 99);
      if (r < 40)      rq.mode = ptts_pkg::MODE_TICK;
      else if (r < 42) rq.mode = ptts_pkg::MODE_REG;
      else if (r < 54) rq.mode = ptts_pkg::MODE_COLLECT;
      else if (r < 62) rq.mode = ptts_pkg::MODE_START;
      else if (r < 68) rq.mode = ptts_pkg::MODE_STOP;
      else if (r < 74) rq.mode = ptts_pkg::MODE_CLEAR;
      else if (r < 88) rq.mode = ptts_pkg::MODE_READ;
      else             rq.mode = ptts_pkg::MODE_DELAY;
      r = $urandom_range(0, 99);
      if (rq.mode == ptts_pkg::MODE_REG) begin
         if (r < 10)      rq.interval = '0;
         else if (r < 70) rq.interval = TICK_W'($urandom_range(1, 12));
         else if (r < 90) rq.interval = TICK_W'($urandom);
         else             rq.interval = TICK_MAX;
      end else if (rq.mode == ptts_pkg::MODE_DELAY) begin
         if (r < 60)      rq.delay_ms = $urandom_range(0, 20);
         else if (r >= 90) rq.delay_ms = '1;
      end else if (rq.mode != ptts_pkg::MODE_TICK && rq.mode != ptts_pkg::MODE_COLLECT) begin
         if (r < 80) rq.timer_index = 2'($urandom_range(0, NTIMER - 1));
      end
      return rq;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || due_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_wrap(input logic [TICK_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      wrap_limit_mdl = v;
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [TICK_W-1:0] wrap, input int s_pct, input int r_pct,
                            input int count, input bit mid_pause);
      wait_drained();
      write_wrap(wrap);
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      for (int i = 0; i < count; i++) begin
         // with mid_pause, hold off the second half until everything outstanding has returned
         if (mid_pause && i == count / 2) wait_drained();
         req_backlog.push_back(random_req());
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_data       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wrap_limit_mdl = ptts_pkg::TICK_WRAP_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed requests at the reset wrap limit
      req_backlog.push_back(make_req(ptts_pkg::MODE_REG, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_REG, 24'd1, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_REG, TICK_MAX, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_REG, 24'd2, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_START, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_START, '0, 2'd1, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_START, '0, 2'd2, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_TICK, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_TICK, TICK_MAX, 2'd3, '1));
      req_backlog.push_back(make_req(ptts_pkg::MODE_COLLECT, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_READ, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_READ, '0, 2'd3, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_STOP, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_STOP, '0, 2'd3, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_DELAY, '0, 2'd0, 32'd2));
      req_backlog.push_back(make_req(ptts_pkg::MODE_TICK, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_TICK, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_TICK, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_READ, '0, 2'd1, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_CLEAR, '0, 2'd1, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_CLEAR, '0, 2'd2, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_READ, '0, 2'd1, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_DELAY, '0, 2'd0, '1));
      req_backlog.push_back(make_req(ptts_pkg::MODE_COLLECT, '0, 2'd0, '0));
      req_backlog.push_back(make_req(ptts_pkg::MODE_DELAY, '0, 2'd0, '0));

      run_phase(24'd1, 48, 0, 150, 1'b0);
      run_phase(24'd0, 0, 48, 100, 1'b0);
      run_phase(TICK_MAX, 30, 30, 150, 1'b0);
      run_phase(24'd7, 0, 0, 200, 1'b1);
      run_phase(TICK_W'($urandom_range(2, 40)), 48, 0, 200, 1'b0);
      run_phase(24'd13, 0, 48, 200, 1'b0);
      run_phase(TICK_W'($urandom), 30, 30, 150, 1'b0);
      run_phase(24'd3, 0, 0, 100, 1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_total == 0 && due_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
